/* rtl/segrect_pkg.sv */
// Shared widths, field offsets, pipeline types and helpers of the segment-rectangle hit test.
package segrect_pkg;

	// Coordinate width (Q12.4 at 16 bits).
	localparam int CW = 16;
	// Coordinate plus one guard bit: sums, differences and far edges.
	localparam int DW = CW + 1;
	// Edge offset and start difference after a possible negation.
	localparam int EW = CW + 2;
	// Size field width (width and height are non-negative).
	localparam int SW = CW - 1;
	// Cross product width and the width of their sum.
	localparam int PW = EW + CW + 1;
	localparam int MW = PW + 1;
	// Rectangle span times segment extent.
	localparam int LW = SW + CW;

	// Input word layout, lowest field first.
	localparam int OFS_X0 = 0;
	localparam int OFS_Y0 = OFS_X0 + CW;
	localparam int OFS_X1 = OFS_Y0 + CW;
	localparam int OFS_Y1 = OFS_X1 + CW;
	localparam int OFS_L  = OFS_Y1 + CW;
	localparam int OFS_T  = OFS_L + CW;
	localparam int OFS_W  = OFS_T + CW;
	localparam int OFS_H  = OFS_W + SW;
	localparam int IN_BITS = OFS_H + SW;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	// Registered first stage: raw fields plus far edges and segment extents.
	typedef struct packed {
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic signed [CW-1:0] l;
		logic signed [CW-1:0] t;
		logic [SW-1:0]        w;
		logic [SW-1:0]        h;
		logic signed [DW-1:0] r;
		logic signed [DW-1:0] b;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} front_t;

	// One edge test: segment c = c0 + t*dc, s = s0 + t*ds against c = k, s in [a, a+span].
	typedef struct packed {
		logic signed [DW-1:0] c0;
		logic signed [DW-1:0] dc;
		logic signed [DW-1:0] k;
		logic signed [DW-1:0] s0;
		logic signed [DW-1:0] ds;
		logic signed [DW-1:0] a;
		logic [SW-1:0]        span;
	} edge_in_t;

	// Per-stage load enables of the pipeline.
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

	// Sign extension of a coordinate by one bit.
	function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
		return DW'(v);
	endfunction

endpackage

/* rtl/segrect_front.sv */
// First pipeline stage: unpacks the input word and forms far edges and segment extents.
module segrect_front (
	input  logic                                clk,
	input  logic                                en_s1,
	input  logic [segrect_pkg::IN_TDATA_W-1:0]  s_tdata,
	output segrect_pkg::front_t                 front_s1
);
	import segrect_pkg::*;

	logic signed [CW-1:0] x0, y0, x1, y1, l, t;
	logic [SW-1:0]        w, h;

	// Field extraction from the input word.
	assign x0 = $signed(s_tdata[OFS_X0 +: CW]);
	assign y0 = $signed(s_tdata[OFS_Y0 +: CW]);
	assign x1 = $signed(s_tdata[OFS_X1 +: CW]);
	assign y1 = $signed(s_tdata[OFS_Y1 +: CW]);
	assign l  = $signed(s_tdata[OFS_L +: CW]);
	assign t  = $signed(s_tdata[OFS_T +: CW]);
	assign w  = s_tdata[OFS_W +: SW];
	assign h  = s_tdata[OFS_H +: SW];

	// Payload register; one add per derived value.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			front_s1.x0 <= x0;
			front_s1.y0 <= y0;
			front_s1.x1 <= x1;
			front_s1.y1 <= y1;
			front_s1.l  <= l;
			front_s1.t  <= t;
			front_s1.w  <= w;
			front_s1.h  <= h;
			front_s1.r  <= sx(l) + $signed(DW'(w));
			front_s1.b  <= sx(t) + $signed(DW'(h));
			front_s1.dx <= sx(x1) - sx(x0);
			front_s1.dy <= sx(y1) - sx(y0);
		end
	end

endmodule

/* rtl/segrect_edge.sv */
// Crossing test of the segment against one rectangle edge, stages two to four.
module segrect_edge (
	input  logic                   clk,
	input  segrect_pkg::pipe_ctl_t ctl,
	input  segrect_pkg::edge_in_t  edge_in,
	output logic                   hit_s4
);
	import segrect_pkg::*;

	logic                 skip_s2;
	logic signed [EW-1:0] n_s2;
	logic [CW-1:0]        d_s2;
	logic signed [EW-1:0] diff_s2;
	logic signed [DW-1:0] ds_s2;
	logic [SW-1:0]        span_s2;

	logic                 ok_s3;
	logic signed [PW-1:0] p1_s3;
	logic signed [PW-1:0] p2_s3;
	logic [LW-1:0]        lim_s3;

	logic signed [MW-1:0] m;

	// Stage two: orient the crossing so the segment extent is non-negative.
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			skip_s2 <= (edge_in.dc == '0) || (edge_in.span == '0);
			if (edge_in.dc[DW-1]) begin
				n_s2 <= EW'(edge_in.c0) - EW'(edge_in.k);
				d_s2 <= CW'(-edge_in.dc);
			end else begin
				n_s2 <= EW'(edge_in.k) - EW'(edge_in.c0);
				d_s2 <= CW'(edge_in.dc);
			end
			diff_s2 <= EW'(edge_in.s0) - EW'(edge_in.a);
			ds_s2   <= edge_in.ds;
			span_s2 <= edge_in.span;
		end
	end

	// Stage three: t range check, the two cross products and the span limit product.
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			ok_s3  <= !skip_s2 && !n_s2[EW-1] && (n_s2 <= $signed(EW'(d_s2)));
			p1_s3  <= PW'(diff_s2) * PW'($signed({1'b0, d_s2}));
			p2_s3  <= PW'(n_s2) * PW'(ds_s2);
			lim_s3 <= LW'(span_s2) * LW'(d_s2);
		end
	end

	// Stage four: u range check, 0 <= m <= span*d.
	assign m = MW'(p1_s3) + MW'(p2_s3);

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			hit_s4 <= ok_s3 && !m[MW-1] && (m <= $signed(MW'(lim_s3)));
		end
	end

endmodule

/* rtl/segment_rect_intersect.sv */
// Top level of the segment versus axis-aligned rectangle hit test.
//
//  channel  | dir | word contents (lowest bit first)
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | start_x, start_y, end_x, end_y, rect_left, rect_top (16 s),
//           |     | rect_width, rect_height (15 u), zero fill to 128 bits
//  m_axis   | out | hit (1), zero fill to 8 bits
//
// Four register stages: input and extents, orientation and containment, cross
// products, final compare. One word is taken every cycle while the output does
// not stall; the result drives the output from the fourth stage. The multipliers
// of the third stage set the clock. Reset clears only the valid bits. An output
// stall holds the occupied stages with no empty stage after them; the rest move up.
module segment_rect_intersect (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// start_x, start_y, end_x, end_y, rect_left, rect_top, rect_width, rect_height
	input  logic [segrect_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// hit
	output logic [segrect_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import segrect_pkg::*;

	logic      vld_s1, vld_s2, vld_s3, vld_s4;
	logic      en_s1;
	pipe_ctl_t ctl;
	front_t    front_s1;
	edge_in_t  edge_in [4];
	logic      edge_hit [4];
	logic      cont_s2, cont_s3, cont_s4;
	logic      in0, in1;
	logic      hit;

	// Stage enables: a stage loads when it is empty or its word moves on.
	assign ctl.en_s4 = !vld_s4 || m_tready;
	assign ctl.en_s3 = !vld_s3 || ctl.en_s4;
	assign ctl.en_s2 = !vld_s2 || ctl.en_s3;
	assign en_s1     = !vld_s1 || ctl.en_s2;
	assign s_tready  = en_s1;

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1)     vld_s1 <= s_tvalid;
			if (ctl.en_s2) vld_s2 <= vld_s1;
			if (ctl.en_s3) vld_s3 <= vld_s2;
			if (ctl.en_s4) vld_s4 <= vld_s3;
		end
	end

	segrect_front u_front (
		.clk      (clk),
		.en_s1    (en_s1),
		.s_tdata  (s_tdata),
		.front_s1 (front_s1)
	);

	// Half-open containment of both endpoints.
	assign in0 = (front_s1.x0 >= front_s1.l) && (sx(front_s1.x0) < front_s1.r)
		&& (front_s1.y0 >= front_s1.t) && (sx(front_s1.y0) < front_s1.b);
	assign in1 = (front_s1.x1 >= front_s1.l) && (sx(front_s1.x1) < front_s1.r)
		&& (front_s1.y1 >= front_s1.t) && (sx(front_s1.y1) < front_s1.b);

	always_ff @(posedge clk) begin
		if (ctl.en_s2) cont_s2 <= in0 || in1;
		if (ctl.en_s3) cont_s3 <= cont_s2;
		if (ctl.en_s4) cont_s4 <= cont_s3;
	end

	// Edge set: top, right, bottom, left.
	always_comb begin
		edge_in[0] = '{c0: sx(front_s1.y0), dc: front_s1.dy, k: sx(front_s1.t),
			s0: sx(front_s1.x0), ds: front_s1.dx, a: sx(front_s1.l), span: front_s1.w};
		edge_in[1] = '{c0: sx(front_s1.x0), dc: front_s1.dx, k: front_s1.r,
			s0: sx(front_s1.y0), ds: front_s1.dy, a: sx(front_s1.t), span: front_s1.h};
		edge_in[2] = '{c0: sx(front_s1.y0), dc: front_s1.dy, k: front_s1.b,
			s0: sx(front_s1.x0), ds: front_s1.dx, a: sx(front_s1.l), span: front_s1.w};
		edge_in[3] = '{c0: sx(front_s1.x0), dc: front_s1.dx, k: sx(front_s1.l),
			s0: sx(front_s1.y0), ds: front_s1.dy, a: sx(front_s1.t), span: front_s1.h};
	end

	for (genvar e = 0; e < 4; e++) begin : g_edge
		segrect_edge u_edge (
			.clk     (clk),
			.ctl     (ctl),
			.edge_in (edge_in[e]),
			.hit_s4  (edge_hit[e])
		);
	end

	// Result word from the last stage registers.
	assign hit      = cont_s4 || edge_hit[0] || edge_hit[1] || edge_hit[2] || edge_hit[3];
	assign m_tvalid = vld_s4;
	assign m_tdata  = OUT_TDATA_W'(hit);

	// An open output never stalls the input.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled although the output is open");

	// An accepted word occupies the first stage next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted word lost at the first stage");

	// A word in stage three always reaches stage four when that stage loads.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && ctl.en_s4) |=> vld_s4)
		else $error("word lost between stages three and four");

	// A held result keeps its flag while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !m_tready) |=> (vld_s4 && $stable(hit)))
		else $error("stalled result changed");

endmodule
